// ----- rtl/asl_pkg.sv -----
`default_nettype none
package asl_pkg;

  localparam int MaxInputLen = 65536;
  localparam int CntW        = $clog2(MaxInputLen + 1);
  localparam int FifoDepth   = 4;
  localparam int FifoAw      = $clog2(FifoDepth);

  localparam logic [7:0] ChX       = 8'h78;  // 'x'
  localparam logic [7:0] ChB       = 8'h62;  // 'b'
  localparam logic [7:0] ChSemi    = 8'h3B;  // ';'
  localparam logic [7:0] ChPercent = 8'h25;  // '%'
  localparam logic [7:0] ChMinus   = 8'h2D;  // '-'
  localparam logic [7:0] ChColon   = 8'h3A;  // ':'
  localparam logic [7:0] ChOpen    = 8'h5B;  // '['
  localparam logic [7:0] ChClose   = 8'h5D;  // ']'
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChVt      = 8'h0B;
  localparam logic [7:0] ChFf      = 8'h0C;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChUscore  = 8'h5F;

  typedef enum logic [3:0] {
    K_EOL     = 4'd0,
    K_NUM     = 4'd1,
    K_IDENT   = 4'd2,
    K_COLON   = 4'd3,
    K_OPEN    = 4'd4,
    K_CLOSE   = 4'd5,
    K_UNKNOWN = 4'd6,
    K_END     = 4'd7,
    K_ERROR   = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    C_LF,
    C_CR,
    C_SPACE,
    C_COMMENT,
    C_MINUS,
    C_DIGIT,
    C_ALPHA,
    C_COLON,
    C_OPEN,
    C_CLOSE,
    C_DOT_US,
    C_OTHER
  } cls_t;

  typedef struct packed {
    logic       is_end;
    cls_t       cls;
    logic [3:0] dval;    // digit or hex digit value
    logic       is_hex;
    logic       is_x;
    logic       is_b;
    logic [7:0] code;
  } item_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  pos;
    logic [15:0]  len;
    logic [31:0]  val;
    logic [7:0]   code;
    logic         last;
  } tok_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/assembly_source_lexer_core.sv -----
// channel | direction | handshake              | payload
// src     | in        | src_valid / src_stall  | req_type, char_byte
// tok     | out       | tok_valid / tok_stall  | token_kind, token_position, ident_length,
//         |           |                        | number_value, char_code, last_of_run
//
// One character per cycle sustained while tok is not stalled; an item that yields several
// tokens (up to 3 at the end marker) holds the lexer stage until the single token output
// register has passed them all on. Path: front register, queue, then token register.
// Synchronous reset returns the lexer to idle with an empty queue.
// Stalls on tok back up through the 4-entry queue before src_stall rises.
`default_nettype none
module assembly_source_lexer_core import asl_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         src_valid,
  output logic              src_stall,
  input  wire logic         req_type,
  input  wire logic [7:0]   char_byte,
  output logic              tok_valid,
  input  wire logic         tok_stall,
  output logic [3:0]        token_kind,
  output logic [15:0]       token_position,
  output logic [15:0]       ident_length,
  output logic signed [31:0] number_value,
  output logic [7:0]        char_code,
  output logic              last_of_run
);

  logic  q_full;
  logic  q_push;
  item_t q_din;
  logic  q_pop;
  logic  q_nonempty;
  item_t q_dout;
  tok_t  tok;

  asl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .req_type  (req_type),
    .char_byte (char_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_din)
  );

  asl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .din      (q_din),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .dout     (q_dout)
  );

  asl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_item     (q_dout),
    .q_pop      (q_pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok        (tok)
  );

  assign token_kind     = tok.kind;
  assign token_position = tok.pos;
  assign ident_length   = tok.len;
  assign number_value   = $signed(tok.val);
  assign char_code      = tok.code;
  assign last_of_run    = tok.last;

endmodule
`default_nettype wire

// ----- rtl/asl_front.sv -----
`default_nettype none
module asl_front import asl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  src_valid,
  output logic       src_stall,
  input  wire logic  req_type,
  input  wire logic [7:0] char_byte,
  input  wire logic  q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic            fv;
  item_t           fitem;
  logic [CntW-1:0] char_count;
  logic            accept;
  logic            keep;
  item_t           cls_item;

  function automatic item_t classify(input logic is_end, input logic [7:0] c);
    item_t r;
    logic  dig;
    logic  lower;
    logic  upper;
    r       = '0;
    dig     = (c >= 8'h30) && (c <= 8'h39);
    lower   = (c >= 8'h61) && (c <= 8'h7A);
    upper   = (c >= 8'h41) && (c <= 8'h5A);
    r.is_end = is_end;
    r.code   = c;
    r.is_x   = (c == ChX);
    r.is_b   = (c == ChB);
    if (dig) begin
      r.dval   = 4'(c - 8'h30);
      r.is_hex = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.dval   = 4'(c - 8'h57);
      r.is_hex = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.dval   = 4'(c - 8'h37);
      r.is_hex = 1'b1;
    end
    if (c == ChLf)                                   r.cls = C_LF;
    else if (c == ChCr)                              r.cls = C_CR;
    else if (c == ChSpace || c == ChTab || c == ChVt ||
             c == ChFf || c == ChComma)              r.cls = C_SPACE;
    else if (c == ChSemi || c == ChPercent)          r.cls = C_COMMENT;
    else if (c == ChMinus)                           r.cls = C_MINUS;
    else if (dig)                                    r.cls = C_DIGIT;
    else if (lower || upper)                         r.cls = C_ALPHA;
    else if (c == ChColon)                           r.cls = C_COLON;
    else if (c == ChOpen)                            r.cls = C_OPEN;
    else if (c == ChClose)                           r.cls = C_CLOSE;
    else if (c == ChDot || c == ChUscore)            r.cls = C_DOT_US;
    else                                             r.cls = C_OTHER;
    return r;
  endfunction

  assign src_stall = fv && q_full;
  assign accept    = src_valid && !src_stall;
  assign q_push    = fv && !q_full;
  assign q_item    = fitem;
  // characters past the input limit are dropped here
  assign keep      = req_type || (char_count < CntW'(MaxInputLen));
  assign cls_item  = classify(req_type, char_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv         <= 1'b0;
      char_count <= '0;
    end else begin
      if (accept && keep) begin
        fv <= 1'b1;
      end else if (q_push) begin
        fv <= 1'b0;
      end
      if (accept) begin
        if (req_type) begin
          char_count <= '0;
        end else if (keep) begin
          char_count <= char_count + CntW'(1);
        end
      end
    end
    if (accept && keep) begin
      fitem <= cls_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/asl_fifo.sv -----
`default_nettype none
module asl_fifo import asl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      din,
  output logic       full,
  input  wire logic  pop,
  output logic       nonempty,
  output item_t      dout
);

  item_t             mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr;
  logic [FifoAw-1:0] rd_ptr;
  logic [FifoAw:0]   count;

  assign full     = (count == (FifoAw+1)'(FifoDepth));
  assign nonempty = (count != '0);
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FifoAw'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FifoAw'(1);
      end
      if (push && !pop) begin
        count <= count + (FifoAw+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FifoAw+1)'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/asl_back.sv -----
`default_nettype none
module asl_back import asl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_nonempty,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       tok_valid,
  input  wire logic  tok_stall,
  output tok_t       tok
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_MINUS, M_ZERO, M_DEC, M_HEX, M_BIN, M_IDENT, M_ERROR
  } mode_t;

  mode_t        mode, mode_next;
  logic         neg, neg_next;
  logic         bstop, bstop_next;
  logic [31:0]  acc, acc_next;
  logic [15:0]  start, start_next;
  logic [15:0]  rlen, rlen_next;
  logic [15:0]  pos, pos_next;
  logic         any_tok, any_tok_next;
  logic         last_eol, last_eol_next;

  tok_t         slot [3];
  logic [1:0]   ocnt;
  tok_t         tk [3];
  logic [1:0]   n;
  logic         disp;
  logic [31:0]  numv;
  logic         any_fin;
  logic         eol_fin;
  logic         take;
  logic         can_load;

  function automatic tok_t mk(input kind_t k, input logic [15:0] p, input logic [15:0] l,
                              input logic [31:0] v, input logic [7:0] c);
    tok_t t;
    t.kind = k;
    t.pos  = p;
    t.len  = l;
    t.val  = v;
    t.code = c;
    t.last = 1'b0;
    return t;
  endfunction

  assign take      = (ocnt != 2'd0) && !tok_stall;
  assign can_load  = (ocnt == 2'd0) || ((ocnt == 2'd1) && !tok_stall);
  assign q_pop     = q_nonempty && can_load;
  assign tok_valid = (ocnt != 2'd0);
  assign tok       = slot[0];
  assign numv      = neg ? (32'd0 - acc) : acc;

  always_comb begin
    mode_next     = mode;
    neg_next      = neg;
    bstop_next    = bstop;
    acc_next      = acc;
    start_next    = start;
    rlen_next     = rlen;
    pos_next      = pos;
    any_tok_next  = any_tok;
    last_eol_next = last_eol;
    tk[0]         = '0;
    tk[1]         = '0;
    tk[2]         = '0;
    n             = 2'd0;
    disp          = 1'b0;
    any_fin       = 1'b0;
    eol_fin       = 1'b0;
    if (q_pop) begin
      if (q_item.is_end) begin
        case (mode)
          M_ZERO, M_DEC, M_HEX, M_BIN: begin
            tk[n] = mk(K_NUM, start, 16'd0, numv, 8'd0);
            n     = n + 2'd1;
          end
          M_IDENT: begin
            tk[n] = mk(K_IDENT, start, rlen, 32'd0, 8'd0);
            n     = n + 2'd1;
          end
          M_MINUS: begin
            tk[n] = mk(K_ERROR, start, 16'd0, 32'd0, 8'd0);
            n     = n + 2'd1;
          end
          default: begin
          end
        endcase
        // a pending token is never an end of line
        any_fin = any_tok || (n != 2'd0);
        eol_fin = (n != 2'd0) ? 1'b0 : last_eol;
        if (any_fin && !eol_fin) begin
          tk[n] = mk(K_EOL, pos, 16'd0, 32'd0, 8'd0);
          n     = n + 2'd1;
        end
        tk[n] = mk(K_END, pos, 16'd0, 32'd0, 8'd0);
        n     = n + 2'd1;
        mode_next     = M_IDLE;
        neg_next      = 1'b0;
        bstop_next    = 1'b0;
        acc_next      = '0;
        start_next    = '0;
        rlen_next     = '0;
        pos_next      = '0;
        any_tok_next  = 1'b0;
        last_eol_next = 1'b0;
      end else begin
        case (mode)
          M_COMMENT: begin
            if (q_item.cls == C_LF) disp = 1'b1;
          end
          M_MINUS: begin
            if (q_item.cls == C_DIGIT) begin
              neg_next   = 1'b1;
              acc_next   = 32'(q_item.dval);
              start_next = pos;
              mode_next  = (q_item.dval == 4'd0) ? M_ZERO : M_DEC;
            end else begin
              tk[n]     = mk(K_ERROR, start, 16'd0, 32'd0, 8'd0);
              n         = n + 2'd1;
              mode_next = M_ERROR;
            end
          end
          M_ZERO: begin
            if (q_item.is_x) begin
              mode_next  = M_HEX;
              acc_next   = '0;
              start_next = sat_inc(pos);
            end else if (q_item.is_b) begin
              mode_next  = M_BIN;
              acc_next   = '0;
              bstop_next = 1'b0;
              start_next = sat_inc(pos);
            end else if (q_item.cls == C_DIGIT) begin
              mode_next = M_DEC;
              acc_next  = 32'(q_item.dval);
            end else begin
              tk[n] = mk(K_NUM, start, 16'd0, numv, 8'd0);
              n     = n + 2'd1;
              disp  = 1'b1;
            end
          end
          M_DEC: begin
            if (q_item.cls == C_DIGIT) begin
              acc_next = (acc << 3) + (acc << 1) + 32'(q_item.dval);
            end else begin
              tk[n] = mk(K_NUM, start, 16'd0, numv, 8'd0);
              n     = n + 2'd1;
              disp  = 1'b1;
            end
          end
          M_HEX: begin
            if (q_item.is_hex) begin
              acc_next = {acc[27:0], q_item.dval};
            end else begin
              tk[n] = mk(K_NUM, start, 16'd0, numv, 8'd0);
              n     = n + 2'd1;
              disp  = 1'b1;
            end
          end
          M_BIN: begin
            if (q_item.cls == C_DIGIT) begin
              // value freezes at the first digit of 2 or more
              if (!bstop && q_item.dval <= 4'd1) begin
                acc_next = {acc[30:0], q_item.dval[0]};
              end else begin
                bstop_next = 1'b1;
              end
            end else begin
              tk[n] = mk(K_NUM, start, 16'd0, numv, 8'd0);
              n     = n + 2'd1;
              disp  = 1'b1;
            end
          end
          M_IDENT: begin
            if (q_item.cls == C_ALPHA || q_item.cls == C_DIGIT || q_item.cls == C_DOT_US) begin
              rlen_next = sat_inc(rlen);
            end else begin
              tk[n] = mk(K_IDENT, start, rlen, 32'd0, 8'd0);
              n     = n + 2'd1;
              disp  = 1'b1;
            end
          end
          M_ERROR: begin
          end
          default: begin
            disp = 1'b1;
          end
        endcase
        if (disp) begin
          mode_next = M_IDLE;
          case (q_item.cls)
            C_LF, C_CR: begin
              tk[n] = mk(K_EOL, pos, 16'd0, 32'd0, 8'd0);
              n     = n + 2'd1;
            end
            C_SPACE: begin
            end
            C_COMMENT: mode_next = M_COMMENT;
            C_MINUS: begin
              mode_next  = M_MINUS;
              start_next = pos;
            end
            C_DIGIT: begin
              mode_next  = (q_item.dval == 4'd0) ? M_ZERO : M_DEC;
              neg_next   = 1'b0;
              acc_next   = 32'(q_item.dval);
              start_next = pos;
            end
            C_ALPHA: begin
              mode_next  = M_IDENT;
              rlen_next  = 16'd1;
              start_next = pos;
            end
            C_COLON: begin
              tk[n] = mk(K_COLON, pos, 16'd0, 32'd0, 8'd0);
              n     = n + 2'd1;
            end
            C_OPEN: begin
              tk[n] = mk(K_OPEN, pos, 16'd0, 32'd0, 8'd0);
              n     = n + 2'd1;
            end
            C_CLOSE: begin
              tk[n] = mk(K_CLOSE, pos, 16'd0, 32'd0, 8'd0);
              n     = n + 2'd1;
            end
            default: begin
              tk[n] = mk(K_UNKNOWN, pos, 16'd0, 32'd0, q_item.code);
              n     = n + 2'd1;
            end
          endcase
        end
        pos_next = sat_inc(pos);
        if (n != 2'd0) begin
          any_tok_next  = 1'b1;
          last_eol_next = (tk[n - 2'd1].kind == K_EOL);
        end
      end
      if (n != 2'd0) begin
        tk[n - 2'd1].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      neg      <= 1'b0;
      bstop    <= 1'b0;
      acc      <= '0;
      start    <= '0;
      rlen     <= '0;
      pos      <= '0;
      any_tok  <= 1'b0;
      last_eol <= 1'b0;
      ocnt     <= 2'd0;
    end else begin
      mode     <= mode_next;
      neg      <= neg_next;
      bstop    <= bstop_next;
      acc      <= acc_next;
      start    <= start_next;
      rlen     <= rlen_next;
      pos      <= pos_next;
      any_tok  <= any_tok_next;
      last_eol <= last_eol_next;
      if (q_pop) begin
        ocnt <= n;
      end else if (take) begin
        ocnt <= ocnt - 2'd1;
      end
    end
    if (q_pop) begin
      slot[0] <= tk[0];
      slot[1] <= tk[1];
      slot[2] <= tk[2];
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule
`default_nettype wire

// ----- tb/assembly_source_lexer_core_tb.sv -----
module assembly_source_lexer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asl_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int CalmTail   = 60;
  localparam int RandomGoal = 250;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_MINUS,
    MODE_ZERO,
    MODE_DEC,
    MODE_HEX,
    MODE_BIN,
    MODE_IDENT,
    MODE_DROP
  } lex_mode_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] pos;
    logic [15:0] len;
    logic [31:0] val;
    logic [7:0]  code;
    logic        last;
  } lex_token_t;

  // hold marks a point where the sender waits for all tokens to drain
  typedef struct {
    logic       hold;
    logic       end_mark;
    logic [7:0] ch;
  } source_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic        req_type = 1'b0;
  logic [7:0]  char_byte = 8'd0;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_position;
  logic [15:0] ident_length;
  logic signed [31:0] number_value;
  logic [7:0]  char_code;
  logic        last_of_run;

  source_item_t source_items[$];
  source_item_t next_item;
  lex_token_t   expected_tokens[$];
  lex_token_t   step_tokens[$];
  lex_token_t   want;

  bit          src_busy = 1'b0;
  int          src_gap = 0;
  int          stall_left = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          token_index = 0;

  // lexer prediction state
  lex_mode_t   lex_mode;
  logic        neg_flag;
  logic        bin_stop;
  logic [31:0] acc;
  logic [15:0] tok_start;
  logic [15:0] run_len;
  logic [15:0] char_pos;
  logic        any_emitted;
  logic        last_eol;
  int          char_count;

  assembly_source_lexer_core DUT (
    .clk            (clk),
    .rst            (rst),
    .src_valid      (src_valid),
    .src_stall      (src_stall),
    .req_type       (req_type),
    .char_byte      (char_byte),
    .tok_valid      (tok_valid),
    .tok_stall      (tok_stall),
    .token_kind     (token_kind),
    .token_position (token_position),
    .ident_length   (ident_length),
    .number_value   (number_value),
    .char_code      (char_code),
    .last_of_run    (last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (is_digit(c)) return int'(c - "0");
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void reset_lexer();
    lex_mode    = MODE_IDLE;
    neg_flag    = 1'b0;
    bin_stop    = 1'b0;
    acc         = 32'd0;
    tok_start   = 16'd0;
    run_len     = 16'd0;
    char_pos    = 16'd0;
    any_emitted = 1'b0;
    last_eol    = 1'b0;
    char_count  = 0;
  endfunction

  function automatic void emit_token(kind_t kind, logic [15:0] pos, logic [15:0] len,
                                     logic [31:0] val, logic [7:0] code);
    lex_token_t t;
    t.kind = kind;
    t.pos  = pos;
    t.len  = len;
    t.val  = val;
    t.code = code;
    t.last = 1'b0;
    step_tokens.push_back(t);
    any_emitted = 1'b1;
    last_eol    = (kind == K_EOL);
  endfunction

  function automatic void emit_number();
    emit_token(K_NUM, tok_start, 16'd0, neg_flag ? 32'd0 - acc : acc, 8'd0);
  endfunction

  function automatic void start_token(logic [7:0] c, logic [15:0] pos);
    lex_mode = MODE_IDLE;
    if (c == ChLf || c == ChCr) emit_token(K_EOL, pos, 16'd0, 32'd0, 8'd0);
    else if (c == ChSpace || c == ChTab || c == ChVt || c == ChFf || c == ChComma) begin
    end else if (c == ChSemi || c == ChPercent) lex_mode = MODE_COMMENT;
    else if (c == ChMinus) begin
      lex_mode  = MODE_MINUS;
      tok_start = pos;
    end else if (is_digit(c)) begin
      lex_mode  = (c == "0") ? MODE_ZERO : MODE_DEC;
      neg_flag  = 1'b0;
      acc       = 32'(c - "0");
      tok_start = pos;
    end else if (is_letter(c)) begin
      lex_mode  = MODE_IDENT;
      run_len   = 16'd1;
      tok_start = pos;
    end else if (c == ChColon) emit_token(K_COLON, pos, 16'd0, 32'd0, 8'd0);
    else if (c == ChOpen) emit_token(K_OPEN, pos, 16'd0, 32'd0, 8'd0);
    else if (c == ChClose) emit_token(K_CLOSE, pos, 16'd0, 32'd0, 8'd0);
    else emit_token(K_UNKNOWN, pos, 16'd0, 32'd0, c);
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [15:0] pos;
    int h;
    pos = char_pos;
    h   = hex_digit(c);
    case (lex_mode)
      MODE_COMMENT: if (c == ChLf) start_token(c, pos);
      MODE_MINUS: begin
        if (is_digit(c)) begin
          neg_flag  = 1'b1;
          acc       = 32'(c - "0");
          tok_start = pos;
          lex_mode  = (c == "0") ? MODE_ZERO : MODE_DEC;
        end else begin
          emit_token(K_ERROR, tok_start, 16'd0, 32'd0, 8'd0);
          lex_mode = MODE_DROP;
        end
      end
      MODE_ZERO: begin
        if (c == ChX) begin
          lex_mode  = MODE_HEX;
          acc       = 32'd0;
          tok_start = bump16(pos);
        end else if (c == ChB) begin
          lex_mode  = MODE_BIN;
          acc       = 32'd0;
          bin_stop  = 1'b0;
          tok_start = bump16(pos);
        end else if (is_digit(c)) begin
          lex_mode = MODE_DEC;
          acc      = 32'(c - "0");
        end else begin
          emit_number();
          start_token(c, pos);
        end
      end
      MODE_DEC: begin
        if (is_digit(c)) acc = acc * 32'd10 + 32'(c - "0");
        else begin
          emit_number();
          start_token(c, pos);
        end
      end
      MODE_HEX: begin
        if (h >= 0) acc = acc * 32'd16 + h[31:0];
        else begin
          emit_number();
          start_token(c, pos);
        end
      end
      MODE_BIN: begin
        if (is_digit(c)) begin
          // value freezes at the first digit that is not binary
          if (!bin_stop && c <= "1") acc = acc * 32'd2 + 32'(c - "0");
          else bin_stop = 1'b1;
        end else begin
          emit_number();
          start_token(c, pos);
        end
      end
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == ChDot || c == ChUscore)
          run_len = bump16(run_len);
        else begin
          emit_token(K_IDENT, tok_start, run_len, 32'd0, 8'd0);
          start_token(c, pos);
        end
      end
      MODE_DROP: begin
      end
      default: start_token(c, pos);
    endcase
    char_pos = bump16(char_pos);
  endfunction

  function automatic void lex_end();
    case (lex_mode)
      MODE_ZERO, MODE_DEC, MODE_HEX, MODE_BIN: emit_number();
      MODE_IDENT: emit_token(K_IDENT, tok_start, run_len, 32'd0, 8'd0);
      MODE_MINUS: emit_token(K_ERROR, tok_start, 16'd0, 32'd0, 8'd0);
      default: begin
      end
    endcase
    if (any_emitted && !last_eol) emit_token(K_EOL, char_pos, 16'd0, 32'd0, 8'd0);
    emit_token(K_END, char_pos, 16'd0, 32'd0, 8'd0);
    reset_lexer();
  endfunction

  function automatic void predict_tokens(logic end_mark, logic [7:0] c);
    step_tokens.delete();
    if (end_mark) lex_end();
    else if (char_count < MaxInputLen) begin
      char_count++;
      lex_char(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic put_char(logic [7:0] c);
    source_item_t it;
    it.hold     = 1'b0;
    it.end_mark = 1'b0;
    it.ch       = c;
    source_items.push_back(it);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic put_end();
    source_item_t it;
    it.hold     = 1'b0;
    it.end_mark = 1'b1;
    it.ch       = 8'($urandom_range(0, 255));
    source_items.push_back(it);
  endtask

  task automatic put_hold();
    source_item_t it;
    it.hold     = 1'b1;
    it.end_mark = 1'b0;
    it.ch       = 8'd0;
    source_items.push_back(it);
  endtask

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  task automatic put_digits(int lo, int hi, string set);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) put_char(pick(set));
  endtask

  task automatic put_literal();
    case ($urandom_range(0, 3))
      0, 1: begin
        put_char(pick("123456789"));
        put_digits(0, 11, "0123456789");
      end
      2: begin
        put_text("0x");
        put_digits(0, 9, "0123456789abcdefABCDEF");
      end
      default: begin
        put_text("0b");
        // mostly binary, now and then a digit that stops the value
        put_digits(0, 36, "01010101010123456789");
      end
    endcase
  endtask

  task automatic put_fragment();
    int n;
    case ($urandom_range(0, 13))
      0, 1: begin
        put_char(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        put_digits(0, 8, "abcXYZ0189._qQ");
      end
      2, 3, 4: put_literal();
      5: begin
        put_char(ChMinus);
        put_literal();
      end
      6, 7: put_char(pick(":[]"));
      8: begin
        put_char(pick(";%"));
        n = $urandom_range(0, 6);
        repeat (n) put_char(8'($urandom_range(0, 255)));
        put_char(ChLf);
      end
      9: put_char(pick("\n\r\n"));
      10: put_char(8'($urandom_range(0, 255)));
      11: begin
        if ($urandom_range(0, 3) == 0) begin
          put_char(ChMinus);
          put_char(pick("a; x-\n"));
        end else put_char(pick(" \t,\v\f"));
      end
      12: begin
        if ($urandom_range(0, 1) == 0) put_char("0");
        else put_text("0X");
      end
      default: put_text("\r\n");
    endcase
    if ($urandom_range(0, 1) == 0) put_char(pick(" \t,"));
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst && !src_busy) begin
      if (src_gap > 0) begin
        src_gap--;
        src_valid <= 1'b0;
      end else if (source_items.size() == 0) begin
        src_valid <= 1'b0;
      end else if (source_items[0].hold) begin
        src_valid <= 1'b0;
        if (expected_tokens.size() == 0) source_items.delete(0);
      end else if (source_items.size() > CalmTail && $urandom_range(0, 11) == 0) begin
        src_gap = $urandom_range(1, 18) - 1;
        src_valid <= 1'b0;
      end else begin
        next_item = source_items.pop_front();
        src_valid <= 1'b1;
        req_type  <= next_item.end_mark;
        char_byte <= next_item.ch;
        src_busy  = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        tok_stall <= 1'b1;
      end else if (source_items.size() > CalmTail && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        tok_stall <= 1'b1;
      end else begin
        tok_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("token %0d: %s got 0x%0h expected 0x%0h", token_index, what, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      quiet_cycles++;
      if (tok_valid && !tok_stall) begin
        quiet_cycles = 0;
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token, kind", 32'(token_kind), 32'd0);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind != want.kind)
            report_mismatch("kind", 32'(token_kind), 32'(want.kind));
          if (token_position != want.pos)
            report_mismatch("position", 32'(token_position), 32'(want.pos));
          if (ident_length != want.len)
            report_mismatch("length", 32'(ident_length), 32'(want.len));
          if (number_value != want.val) report_mismatch("value", number_value, want.val);
          if (char_code != want.code)
            report_mismatch("char", 32'(char_code), 32'(want.code));
          if (last_of_run != want.last)
            report_mismatch("last", 32'(last_of_run), 32'(want.last));
        end
        token_index++;
      end
      // the transfer is predicted after the token check: no same-edge result
      if (src_valid && !src_stall) begin
        quiet_cycles = 0;
        predict_tokens(req_type, char_byte);
        src_busy = 1'b0;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int target;
    reset_lexer();

    // directed: minus before a digit, empty hex prefix, binary stop,
    // CR inside a comment, NUL and high bytes, minus error, empty input
    put_text("-7 0x 0b1021%z\r\nQ");
    put_char(8'h00);
    put_char(8'hFF);
    put_end();
    put_text("-q9");
    put_end();
    put_end();
    put_hold();

    target = source_items.size() + RandomGoal;
    while (source_items.size() < target) begin
      repeat ($urandom_range(3, 10)) put_fragment();
      put_end();
      if (source_items.size() > target - RandomGoal / 2 && source_items.size() < target - 80)
        if ($urandom_range(0, 2) == 0) put_hold();
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (source_items.size() != 0 || src_busy || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
